### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/rvec_pkg.sv
// ----------------------------------------------------------------------------
// rvec_pkg
// Fixed widths and constants of the refraction vector pipeline.
// ----------------------------------------------------------------------------
package rvec_pkg;

	localparam int IN_W  = 16;	// vector component width
	localparam int ETA_W = 16;	// refraction ratio width
	localparam int OUT_W = 20;	// result component width
	localparam int SQ_R  = 4;	// root bits resolved per square-root stage

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

### rtl/core/rvec_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rvec_sqrt_pipe
// Pipelined integer square root (floor), SQ_R root bits per stage, with a
// sideband word carried alongside.
// ----------------------------------------------------------------------------
module rvec_sqrt_pipe import rvec_pkg::*; #(
	parameter int RAD_W = 43,
	parameter int SB_W  = 8,
	localparam int NS     = ((RAD_W + 1) / 2 + SQ_R - 1) / SQ_R,
	localparam int ROOT_W = NS * SQ_R
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROOT_W-1:0] out_root,
	output logic [SB_W-1:0]   out_sb
);

	localparam int PAD_W = 2 * ROOT_W;
	localparam int RM_W  = ROOT_W + 3;

	logic              v_s    [NS];
	logic              en     [NS];
	logic [PAD_W-1:0]  rad_s  [NS];
	logic [RM_W-1:0]   rem_s  [NS];
	logic [ROOT_W-1:0] root_s [NS];
	logic [SB_W-1:0]   sb_s   [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [PAD_W-1:0]  cur_rad;
		logic [RM_W-1:0]   cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [SB_W-1:0]   cur_sb;
		logic              cur_v;
		logic [PAD_W-1:0]  nxt_rad;
		logic [RM_W-1:0]   nxt_rem;
		logic [ROOT_W-1:0] nxt_root;

		if (j == 0) begin : g_first
			assign cur_rad  = PAD_W'(in_rad);
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_sb   = in_sb;
			assign cur_v    = in_valid;
		end else begin : g_next
			assign cur_rad  = rad_s[j-1];
			assign cur_rem  = rem_s[j-1];
			assign cur_root = root_s[j-1];
			assign cur_sb   = sb_s[j-1];
			assign cur_v    = v_s[j-1];
		end

		if (j == NS - 1) begin : g_en_last
			assign en[j] = !v_s[j] || !out_stall;
		end else begin : g_en_mid
			assign en[j] = !v_s[j] || en[j+1];
		end

		// restoring digit recurrence, two radicand bits per step
		always_comb begin
			logic [PAD_W-1:0]  rd;
			logic [RM_W-1:0]   rm;
			logic [RM_W-1:0]   trial;
			logic [ROOT_W-1:0] rt;
			rd = cur_rad;
			rm = cur_rem;
			rt = cur_root;
			for (int i = 0; i < SQ_R; i++) begin
				rm    = {rm[RM_W-3:0], rd[PAD_W-1 -: 2]};
				rd    = rd << 2;
				trial = {1'b0, rt, 2'b01};
				if (rm >= trial) begin
					rm = rm - trial;
					rt = {rt[ROOT_W-2:0], 1'b1};
				end else begin
					rt = {rt[ROOT_W-2:0], 1'b0};
				end
			end
			nxt_rad  = rd;
			nxt_rem  = rm;
			nxt_root = rt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rad_s[j]  <= nxt_rad;
				rem_s[j]  <= nxt_rem;
				root_s[j] <= nxt_root;
				sb_s[j]   <= cur_sb;
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_sb    = sb_s[NS-1];

endmodule

### rtl/core/refraction_vector_top.sv
// ----------------------------------------------------------------------------
// refraction_vector_top
// Fixed-point refract() of a 3-component direction: eta*I - (eta*d + sqrt(k))*N
// with d = I.N, k = 1 - eta^2 (1 - d^2); total internal reflection when k <= 0.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_stall    | incident_x/y/z, normal_x/y/z, eta
//  out     | out_valid / out_stall  | refracted_x/y/z, total_reflection
//
// One word per cycle sustained while out_stall is low. The square root of
// k * 2^F, resolved SQ_R bits per stage over NS square-root stages, sets the
// pipeline depth. arst_n clears all stage valid bits; the datapath registers
// are not reset. Each stage advances when it is empty or the stage after it
// advances, so bubbles close up under out_stall and in_stall rises only when
// every stage holds a word and the output is stalled.
// ----------------------------------------------------------------------------
module refraction_vector_top import rvec_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [IN_W-1:0]  incident_x,
	input  logic signed [IN_W-1:0]  incident_y,
	input  logic signed [IN_W-1:0]  incident_z,
	input  logic signed [IN_W-1:0]  normal_x,
	input  logic signed [IN_W-1:0]  normal_y,
	input  logic signed [IN_W-1:0]  normal_z,
	input  logic [ETA_W-1:0]        eta,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] refracted_x,
	output logic signed [OUT_W-1:0] refracted_y,
	output logic signed [OUT_W-1:0] refracted_z,
	output logic                    total_reflection
);

	// ---- derived widths ----
	localparam int PR_W   = 2 * IN_W;                  // I_c * N_c
	localparam int DF_W   = PR_W + 2;                  // full dot product
	localparam int DQ_W   = DF_W - FRAC_BITS;          // d, F fraction bits
	localparam int DDP_W  = 2 * DQ_W;                  // d * d
	localparam int DD_W   = (65 - 3 * FRAC_BITS > 1) ? 65 - 3 * FRAC_BITS : 1;
	localparam int T_W    = ((DD_W > FRAC_BITS + 1) ? DD_W : FRAC_BITS + 1) + 1;
	localparam int E2_W   = 2 * ETA_W - FRAC_BITS;     // eta^2
	localparam int KP_W   = E2_W + 1 + T_W;            // eta^2 * t
	localparam int KS_W   = KP_W - FRAC_BITS;
	localparam int ONE_W  = FRAC_BITS + 2;
	localparam int K_W    = ((KS_W > ONE_W) ? KS_W : ONE_W) + 1;
	localparam int RAD_W  = K_W - 1 + FRAC_BITS;       // k * 2^F
	localparam int NS     = ((RAD_W + 1) / 2 + SQ_R - 1) / SQ_R;
	localparam int ROOT_W = NS * SQ_R;
	localparam int EDP_W  = ETA_W + 1 + DQ_W;          // eta * d
	localparam int ED_W   = (EDP_W - FRAC_BITS > 2) ? EDP_W - FRAC_BITS : 2;
	localparam int EIP_W  = ETA_W + 1 + IN_W;          // eta * I_c
	localparam int EI_W   = EIP_W - FRAC_BITS;
	localparam int M_W    = ((ED_W > ROOT_W + 1) ? ED_W : ROOT_W + 1) + 1;
	localparam int NM_W   = IN_W + M_W;                // N_c * m
	localparam int NMS_W  = NM_W - FRAC_BITS;
	localparam int R_W    = ((NMS_W > EI_W) ? NMS_W : EI_W) + 1;
	localparam int RX_W   = (R_W > OUT_W) ? R_W : OUT_W;

	// sideband that rides through the square root
	typedef struct packed {
		logic                       tir;
		logic [ED_W-1:0]            ed;
		logic [2:0][EI_W-1:0]       ei;
		logic [2:0][IN_W-1:0]       nrm;
	} sb_t;

	localparam int SB_W = $bits(sb_t);

	// ---- stage enables (bubble-collapsing) ----
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic sq_in_stall, sq_out_valid;

	assign en5      = !v_s5 || !out_stall;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || !sq_in_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= sq_out_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	// ---- stage 1: dot product, eta^2, eta*I ----
	logic signed [IN_W-1:0] inc [3];
	logic signed [IN_W-1:0] nrm [3];
	logic signed [PR_W-1:0] dp  [3];
	logic signed [EI_W-1:0] ei_c [3];
	logic signed [DF_W-1:0] dfull;
	logic [2*ETA_W-1:0]     eta_sq;

	assign inc[0] = incident_x;
	assign inc[1] = incident_y;
	assign inc[2] = incident_z;
	assign nrm[0] = normal_x;
	assign nrm[1] = normal_y;
	assign nrm[2] = normal_z;

	for (genvar c = 0; c < 3; c++) begin : g_s1
		logic signed [EIP_W-1:0] eip;
		assign dp[c]   = inc[c] * nrm[c];
		assign eip     = $signed({1'b0, eta}) * inc[c];
		assign ei_c[c] = EI_W'(eip >>> FRAC_BITS);
	end

	assign dfull  = DF_W'(dp[0]) + DF_W'(dp[1]) + DF_W'(dp[2]);
	assign eta_sq = eta * eta;

	logic signed [DQ_W-1:0] dq_s1;
	logic [E2_W-1:0]        e2_s1;
	logic [ETA_W-1:0]       eta_s1;
	logic [2:0][EI_W-1:0]   ei_s1;
	logic [2:0][IN_W-1:0]   nrm_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			dq_s1  <= DQ_W'(dfull >>> FRAC_BITS);
			e2_s1  <= E2_W'(eta_sq >> FRAC_BITS);
			eta_s1 <= eta;
			for (int c = 0; c < 3; c++) begin
				ei_s1[c]  <= ei_c[c];
				nrm_s1[c] <= nrm[c];
			end
		end
	end

	// ---- stage 2: t = 1 - d^2, eta*d ----
	logic signed [DDP_W-1:0] ddp;
	logic [DD_W-1:0]         dd;
	logic signed [EDP_W-1:0] edp;

	assign ddp = dq_s1 * dq_s1;
	assign dd  = DD_W'($unsigned(ddp) >> FRAC_BITS);
	assign edp = $signed({1'b0, eta_s1}) * dq_s1;

	logic signed [T_W-1:0]  t_s2;
	logic [E2_W-1:0]        e2_s2;
	logic [ED_W-1:0]        ed_s2;
	logic [2:0][EI_W-1:0]   ei_s2;
	logic [2:0][IN_W-1:0]   nrm_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			t_s2   <= (T_W'(1) << FRAC_BITS) - T_W'(dd);
			e2_s2  <= e2_s1;
			ed_s2  <= ED_W'(edp >>> FRAC_BITS);
			ei_s2  <= ei_s1;
			nrm_s2 <= nrm_s1;
		end
	end

	// ---- stage 3: k = 1 - eta^2 * t, radicand ----
	logic signed [KP_W-1:0] kp;
	logic signed [KS_W-1:0] ks;
	logic signed [K_W-1:0]  k;
	logic                   tir_c;

	assign kp    = $signed({1'b0, e2_s2}) * t_s2;
	assign ks    = KS_W'(kp >>> FRAC_BITS);
	assign k     = (K_W'(1) << FRAC_BITS) - K_W'(ks);
	assign tir_c = k[K_W-1] || (k == '0);

	logic [RAD_W-1:0] rad_s3;
	sb_t              sb_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			rad_s3    <= tir_c ? '0 : {k[K_W-2:0], {FRAC_BITS{1'b0}}};
			sb_s3.tir <= tir_c;
			sb_s3.ed  <= ed_s2;
			sb_s3.ei  <= ei_s2;
			sb_s3.nrm <= nrm_s2;
		end
	end

	// ---- square root stages ----
	logic [ROOT_W-1:0] sq_root;
	logic [SB_W-1:0]   sq_sb_bits;
	sb_t               sq_sb;

	rvec_sqrt_pipe #(
		.RAD_W (RAD_W),
		.SB_W  (SB_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_stall  (sq_in_stall),
		.in_rad    (rad_s3),
		.in_sb     (SB_W'(sb_s3)),
		.out_valid (sq_out_valid),
		.out_stall (!en4),
		.out_root  (sq_root),
		.out_sb    (sq_sb_bits)
	);

	assign sq_sb = sb_t'(sq_sb_bits);

	// ---- stage 4: m = eta*d + sqrt(k) ----
	logic signed [M_W-1:0] m_s4;
	sb_t                   sb_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			m_s4  <= M_W'($signed(sq_sb.ed)) + M_W'(sq_root);
			sb_s4 <= sq_sb;
		end
	end

	// ---- stage 5: eta*I - N*m, saturate, zero on reflection ----
	logic signed [OUT_W-1:0] res_c [3];

	for (genvar c = 0; c < 3; c++) begin : g_s5
		logic signed [NM_W-1:0]  nm;
		logic signed [NMS_W-1:0] nms;
		logic signed [RX_W-1:0]  r;
		assign nm  = $signed(sb_s4.nrm[c]) * m_s4;
		assign nms = NMS_W'(nm >>> FRAC_BITS);
		assign r   = RX_W'(R_W'($signed(sb_s4.ei[c])) - R_W'(nms));
		always_comb begin
			if (sb_s4.tir) begin
				res_c[c] = '0;
			end else if (r > RX_W'(OUT_MAX)) begin
				res_c[c] = OUT_MAX;
			end else if (r < RX_W'(OUT_MIN)) begin
				res_c[c] = OUT_MIN;
			end else begin
				res_c[c] = OUT_W'(r);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			refracted_x      <= res_c[0];
			refracted_y      <= res_c[1];
			refracted_z      <= res_c[2];
			total_reflection <= sb_s4.tir;
		end
	end

	assign out_valid = v_s5;

endmodule

### rtl/core/rvec_checker.sv
// ----------------------------------------------------------------------------
// rvec_checker
// Port-level checks of refraction_vector_top, bound to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvec_checker import rvec_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] refracted_x,
	input logic signed [OUT_W-1:0] refracted_y,
	input logic signed [OUT_W-1:0] refracted_z,
	input logic                    total_reflection
);

	// reflection word carries a zero vector
	`RV_ASSERT_IMPL(a_tir_zero, out_valid && total_reflection, refracted_x == '0 && refracted_y == '0 && refracted_z == '0, "reflection word with nonzero vector")

	// input backs up only while a valid output word is stalled
	`RV_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without a stalled output word")

	// stalled output word holds
	`RV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(refracted_x) && $stable(refracted_y) && $stable(refracted_z) && $stable(total_reflection), "stalled output word changed")

endmodule

bind refraction_vector_top rvec_checker u_rvec_checker (.*);

### sim/tb_refraction_vector_top.sv
// ----------------------------------------------------------------------------
// tb_refraction_vector_top
// Self-checking bench for the fixed-point refract() pipeline: random and corner
// vectors go in under varying idle/stall pressure, each output word is checked
// against a behavioral prediction of the same integer arithmetic.
// ----------------------------------------------------------------------------
module tb_refraction_vector_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rvec_pkg::*;

	localparam int FB = 14;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic signed [IN_W-1:0] ix, iy, iz, nx, ny, nz;
		logic [ETA_W-1:0]       eta;
	} ray_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] rx, ry, rz;
		logic                    tir;
	} bend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [IN_W-1:0] incident_x = '0, incident_y = '0, incident_z = '0;
	logic signed [IN_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic [ETA_W-1:0] eta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] refracted_x, refracted_y, refracted_z;
	logic total_reflection;

	refraction_vector_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ray_t  ray_q[$];	// words waiting to be driven
	bend_t bend_q[$];	// predicted results, oldest first
	int idle_pct = 0;	// sender idle percentage
	int stall_pct = 0;	// receiver stall percentage
	int errors = 0;
	int cycles = 0;
	bit stim_done = 1'b0;

	// floor division by 2^FB for signed operands (>>> on signed is arithmetic)
	function automatic longint fshr(longint v);
		return v >>> FB;
	endfunction

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp(longint v);
		if (v > longint'(OUT_MAX)) return OUT_MAX;
		if (v < longint'(OUT_MIN)) return OUT_MIN;
		return v[OUT_W-1:0];
	endfunction

	// expected refracted direction for one ray
	function automatic bend_t refract_of(ray_t w);
		longint one, e, d, dq, dd, t, e2, k, s, m;
		longint iv[3], nv[3];
		bend_t r;
		one = 64'sd1 <<< FB;
		iv[0] = w.ix; iv[1] = w.iy; iv[2] = w.iz;
		nv[0] = w.nx; nv[1] = w.ny; nv[2] = w.nz;
		e = longint'({1'b0, w.eta});
		d = iv[0]*nv[0] + iv[1]*nv[1] + iv[2]*nv[2];
		dq = fshr(d);
		dd = (dq*dq) >>> FB;
		t = one - dd;
		e2 = (e*e) >>> FB;
		// floor of a negative product equals minus the ceiling of its magnitude
		k = one - fshr(e2*t);
		r = '0;
		if (k <= 0) begin
			r.tir = 1'b1;
			return r;
		end
		s = isqrt(k <<< FB);
		m = fshr(e*dq) + s;
		r.rx = clamp(fshr(e*iv[0]) - fshr(nv[0]*m));
		r.ry = clamp(fshr(e*iv[1]) - fshr(nv[1]*m));
		r.rz = clamp(fshr(e*iv[2]) - fshr(nv[2]*m));
		return r;
	endfunction

	// driver: holds the word while stalled, may idle between words
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (ray_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					ray_t w;
					w = ray_q.pop_front();
					bend_q.push_back(refract_of(w));
					in_valid   <= 1'b1;
					incident_x <= w.ix; incident_y <= w.iy; incident_z <= w.iz;
					normal_x   <= w.nx; normal_y   <= w.ny; normal_z   <= w.nz;
					eta        <= w.eta;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: compare each accepted output word with the oldest prediction
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (bend_q.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d z=%0d tir=%0b", $time,
					refracted_x, refracted_y, refracted_z, total_reflection);
				errors <= errors + 1;
			end else begin
				bend_t x;
				x = bend_q.pop_front();
				if (x.rx !== refracted_x || x.ry !== refracted_y ||
						x.rz !== refracted_z || x.tir !== total_reflection) begin
					$display("%0t: expected x=%0d y=%0d z=%0d tir=%0b, got x=%0d y=%0d z=%0d tir=%0b",
						$time, x.rx, x.ry, x.rz, x.tir,
						refracted_x, refracted_y, refracted_z, total_reflection);
					errors <= errors + 1;
				end
			end
		end
	end

	function automatic logic [15:0] rnd16();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h4000;	// +1.0
			3: return 16'hc000;	// -1.0
			default: return 16'($urandom);
		endcase
	endfunction

	// random ray: raw random words with corner fields, or roughly unit-length vectors
	function automatic ray_t rnd_ray();
		ray_t w;
		int a;
		if ($urandom_range(3) == 0) begin
			w = ray_t'($bits(ray_t)'({$urandom, $urandom, $urandom, $urandom}));
			w.ix = rnd16(); w.nz = rnd16(); w.eta = rnd16();
		end else begin
			a = $urandom_range(9000);
			w.ix = 16'($signed(a) - 4500);
			w.iy = 16'($urandom_range(11000)) - 16'sd5500;
			w.iz = -16'sd14000 + 16'($urandom_range(4000));
			w.nx = 16'($urandom_range(3000)) - 16'sd1500;
			w.ny = 16'($urandom_range(3000)) - 16'sd1500;
			w.nz = 16'sd16000 + 16'($urandom_range(384));
			w.eta = 16'($urandom_range(8000, 30000));
		end
		return w;
	endfunction

	task automatic drain();
		while (ray_q.size() > 0 || bend_q.size() > 0 || in_valid) @(posedge clk);
	endtask

	initial begin
		ray_t w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: axis hits, grazing, field extremes, total internal reflection
		ray_q.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd16384});
		ray_q.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd12000});
		ray_q.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd24000});
		ray_q.push_back('{16'sd16000, 16'sd0, -16'sd3000, 16'sd0, 16'sd0, 16'sd16384, 16'd26000});
		ray_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff});
		ray_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff});
		ray_q.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'h0000});
		ray_q.push_back('{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'h0000});
		ray_q.push_back('{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'hffff});
		ray_q.push_back('{16'sh7fff, 16'sh0, 16'sh0, 16'sh8000, 16'sh0, 16'sh0, 16'hffff});
		ray_q.push_back('{16'sh8000, 16'sh7fff, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh0, 16'h8000});
		ray_q.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'h5555});
		ray_q.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'haaaa});
		drain();

		// random part in four pressure phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			for (int i = 0; i < 200; i++) begin
				w = rnd_ray();
				ray_q.push_back(w);
			end
			drain();
		end
		stim_done = 1'b1;
	end

	// end of run: settle once predictions are drained, or time out
	initial begin
		wait (stim_done);
		repeat (40) @(posedge clk);
		if (errors == 0 && bend_q.size() == 0)
			$display("tb_refraction_vector_top OK");
		else
			$display("tb_refraction_vector_top NOT OK");
		$finish;
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("tb_refraction_vector_top NOT OK");
		$finish;
	end

endmodule
